// ----- hw/rtl/pba_pkg.sv -----
// Shared types, codes and field layout for the page bitmap allocator.
`timescale 1ns / 1ps

package pba_pkg;

  // Default sizing of the used/free store.
  localparam int DEF_NUM_PAGES = 65536;
  localparam int DEF_WORD_BITS = 32;

  // Field widths.
  localparam int ACTION_W = 3;
  localparam int ADDR_W   = 32;
  localparam int INDEX_W  = 16;
  localparam int LEN_W    = 17;
  localparam int STATUS_W = 2;
  localparam int SHIFT_W  = 5;
  localparam int PAGES_W  = 17;

  // Input word layout: page_address, page_index, range_length from bit 0 up.
  localparam int IN_DATA_W    = 72;
  localparam int PADDR_LSB    = 0;
  localparam int PIDX_LSB     = PADDR_LSB + ADDR_W;
  localparam int PLEN_LSB     = PIDX_LSB + INDEX_W;
  localparam int OUT_DATA_W   = 32;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SHIFT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGES_IN_USE = 1'd1;

  localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RST   = 5'd12;
  localparam logic [PAGES_W-1:0] PAGES_IN_USE_RST = 17'h10000;

  // Action codes.
  localparam logic [ACTION_W-1:0] ACT_ALLOC     = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE      = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_SET       = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_CLR       = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_SET_RANGE = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_CLR_RANGE = 3'd5;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 2'd2;

  localparam logic [ADDR_W-1:0] ADDR_NONE = 32'hFFFF_FFFF;

  // Controller to datapath.
  typedef struct packed {
    logic idle;
    logic clear;
    logic check;
    logic div_step;
    logic prime;
    logic walk;
    logic load_out;
  } pba_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clr_done;
    logic is_alloc;
    logic need_walk;
    logic walk_done;
    logic out_free;
  } pba_stat_t;

endpackage

// ----- hw/rtl/pba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/pba_ctrl.sv -----
// Controller state machine for the page bitmap allocator.
`timescale 1ns / 1ps

module pba_ctrl
  import pba_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  input  pba_stat_t stat,
  output pba_cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_PRIME  = 3'd4;
  localparam logic [2:0] S_WALK   = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (s_tvalid) state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (stat.is_alloc) begin
          state_next = S_PRIME;
        end else if (stat.need_walk) begin
          state_next = S_DIV;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        state_next   = S_PRIME;
      end
      S_PRIME: begin
        cmd.prime  = 1'b1;
        state_next = S_WALK;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (stat.walk_done) state_next = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/pba_datapath.sv -----
// Datapath: configuration, item decode, start-word divider, bitmap walk and result word.
`timescale 1ns / 1ps

module pba_datapath
  import pba_pkg::*;
#(
  parameter int NUM_PAGES = DEF_NUM_PAGES,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pba_cmd_t              cmd,
  output pba_stat_t             stat,
  input  logic                  s_tvalid,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [ACTION_W-1:0]   s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [STATUS_W-1:0]   m_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int STORE_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W     = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int IDX_W       = $clog2(NUM_PAGES);
  localparam int LIM_W       = $clog2(NUM_PAGES + 1);
  localparam int LW          = (LIM_W > PAGES_W) ? LIM_W : PAGES_W;
  localparam int POS_W       = $clog2(NUM_PAGES + 2 * WORD_BITS);
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int OFF_W       = $clog2(WORD_BITS + 1);
  localparam int REM_W       = BIT_W + 1;
  localparam int CMP_W       = ADDR_W + 1;
  localparam int QSH         = IDX_W + BIT_W;
  localparam int RCP_W       = IDX_W + 2;
  localparam int PROD_W      = IDX_W + RCP_W;
  localparam longint RECIP   = ((longint'(1) << QSH) + longint'(WORD_BITS) - 1) /
                               longint'(WORD_BITS);

  // Configuration registers.
  logic [SHIFT_W-1:0] page_shift;
  logic [PAGES_W-1:0] pages_in_use;

  // Latched item.
  logic [ACTION_W-1:0] act;
  logic [ADDR_W-1:0]   paddr;
  logic [INDEX_W-1:0]  pidx;
  logic [LEN_W-1:0]    plen;

  // Decoded range.
  logic [IDX_W-1:0] start;
  logic [LIM_W-1:0] hi;

  // Start word and bit offset.
  logic [IDX_W-1:0]  quo;
  logic [REM_W-1:0]  rem;
  logic [PROD_W-1:0] prod;
  logic [IDX_W-1:0]  quo_c;
  logic [IDX_W-1:0]  qwb;
  logic [REM_W-1:0]  rem_c;

  // Walk position.
  logic [WADDR_W-1:0] wcnt;
  logic [POS_W-1:0]   base;
  logic [OFF_W-1:0]   lo_off;
  logic [WADDR_W-1:0] clr;

  // Result.
  logic [STATUS_W-1:0] res_status;
  logic [ADDR_W-1:0]   res_addr;

  // RAM port.
  logic                 ram_we;
  logic [WADDR_W-1:0]   ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WADDR_W-1:0]   ram_raddr;
  logic [WORD_BITS-1:0] rdata;

  // Combinational helpers.
  logic [LIM_W-1:0]     lim;
  logic [LW-1:0]        pages_lw;
  logic                 is_alloc;
  logic                 is_free;
  logic                 is_single;
  logic                 is_range;
  logic                 is_mod;
  logic                 set_bits;
  logic [CMP_W-1:0]     start33;
  logic [CMP_W-1:0]     len33;
  logic [CMP_W-1:0]     end33;
  logic [CMP_W-1:0]     lim33;
  logic                 oor;
  logic [LIM_W-1:0]     hi_c;
  logic                 any_zero;
  logic [BIT_W-1:0]     b_low;
  logic [POS_W-1:0]     idx;
  logic                 w_fail;
  logic                 idx_ok;
  logic [POS_W-1:0]     hi_diff;
  logic [OFF_W-1:0]     hi_off;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] one_bit;
  logic [WORD_BITS-1:0] range_word;
  logic                 r_done;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_shift   <= PAGE_SHIFT_RST;
      pages_in_use <= PAGES_IN_USE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PAGE_SHIFT:   page_shift   <= cfg_data[SHIFT_W-1:0];
        REG_PAGES_IN_USE: pages_in_use <= cfg_data[PAGES_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective limit is the smaller of the register and the store size.
  assign pages_lw = LW'(pages_in_use);
  assign lim      = (pages_lw < LW'(NUM_PAGES)) ? LIM_W'(pages_lw) : LIM_W'(NUM_PAGES);

  always_comb begin
    is_alloc  = (act == ACT_ALLOC);
    is_free   = (act == ACT_FREE);
    is_single = (act == ACT_SET) || (act == ACT_CLR);
    is_range  = (act == ACT_SET_RANGE) || (act == ACT_CLR_RANGE);
    is_mod    = is_free || is_single || is_range;
    set_bits  = (act == ACT_SET) || (act == ACT_SET_RANGE);
    start33   = is_free ? {1'b0, paddr >> page_shift} : CMP_W'(pidx);
    len33     = is_range ? CMP_W'(plen) : CMP_W'(1);
    end33     = start33 + len33;
    lim33     = CMP_W'(lim);
    oor       = (start33 >= lim33);
    hi_c      = (end33 > lim33) ? lim : LIM_W'(end33);
  end

  // Start word by reciprocal multiplication, exact for every index below
  // 2**IDX_W; the bit offset is what is left over.
  assign prod  = PROD_W'(start) * PROD_W'(RECIP);
  assign quo_c = IDX_W'(prod >> QSH);
  assign qwb   = quo_c * IDX_W'(WORD_BITS);
  assign rem_c = REM_W'(start - qwb);

  // Lowest free bit of the word being examined.
  always_comb begin
    b_low = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!rdata[b]) b_low = BIT_W'(b);
    end
  end

  always_comb begin
    any_zero   = ~&rdata;
    idx        = base + POS_W'(b_low);
    w_fail     = (base >= POS_W'(lim));
    idx_ok     = (idx < POS_W'(lim));
    one_bit    = WORD_BITS'(1) << b_low;
    hi_diff    = POS_W'(hi) - base;
    hi_off     = (hi_diff >= POS_W'(WORD_BITS)) ? OFF_W'(WORD_BITS) : OFF_W'(hi_diff);
    for (int b = 0; b < WORD_BITS; b++) begin
      mask[b] = (OFF_W'(b) >= lo_off) && (OFF_W'(b) < hi_off);
    end
    range_word = set_bits ? (rdata | mask) : (rdata & ~mask);
    r_done     = (base + POS_W'(WORD_BITS)) >= POS_W'(hi);
  end

  always_comb begin
    stat.clr_done  = (clr == WADDR_W'(STORE_WORDS - 1));
    stat.is_alloc  = is_alloc;
    stat.need_walk = is_mod && !oor && (end33 != start33);
    stat.walk_done = is_alloc ? (w_fail || any_zero) : r_done;
    stat.out_free  = !m_tvalid || m_tready;
  end

  // Store port: clearing pass, or read-modify-write of the word at wcnt
  // while the next word is already being read.
  always_comb begin
    ram_we    = cmd.clear ||
                (cmd.walk && (is_alloc ? (!w_fail && any_zero && idx_ok) : 1'b1));
    ram_waddr = cmd.clear ? clr : wcnt;
    ram_wdata = cmd.clear ? '0 : (is_alloc ? (rdata | one_bit) : range_word);
    if (cmd.prime) begin
      ram_raddr = is_alloc ? '0 : WADDR_W'(quo);
    end else begin
      ram_raddr = wcnt + WADDR_W'(1);
    end
  end

  pba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (cmd.clear) begin
      clr <= clr + WADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idle && s_tvalid) begin
      act   <= s_tuser;
      paddr <= s_tdata[PADDR_LSB +: ADDR_W];
      pidx  <= s_tdata[PIDX_LSB +: INDEX_W];
      plen  <= s_tdata[PLEN_LSB +: LEN_W];
    end

    if (cmd.check) begin
      res_addr   <= ADDR_NONE;
      res_status <= (is_mod && oor) ? ST_OUT_OF_RANGE : ST_DONE;
      hi         <= hi_c;
      start      <= IDX_W'(start33);
    end

    if (cmd.div_step) begin
      quo <= quo_c;
      rem <= rem_c;
    end

    if (cmd.prime) begin
      if (is_alloc) begin
        wcnt   <= '0;
        base   <= '0;
        lo_off <= '0;
      end else begin
        wcnt   <= WADDR_W'(quo);
        base   <= POS_W'(start) - POS_W'(rem);
        lo_off <= OFF_W'(rem);
      end
    end

    if (cmd.walk) begin
      wcnt   <= wcnt + WADDR_W'(1);
      base   <= base + POS_W'(WORD_BITS);
      lo_off <= '0;
      if (is_alloc) begin
        if (w_fail || (any_zero && !idx_ok)) begin
          res_status <= ST_NO_FREE;
        end else if (any_zero) begin
          res_status <= ST_DONE;
          res_addr   <= ADDR_W'(idx) << page_shift;
        end
      end
    end
  end

  // Result word register; holds until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= res_addr;
      m_tuser <= res_status;
    end
  end

endmodule

// ----- hw/rtl/page_bitmap_allocator.sv -----
// Page bitmap allocator: one used/free bit per page with first-fit allocation.
//
// After reset the block first runs a clearing pass over the bitmap store, one
// store word per cycle (2048 words at the default 65536 pages of 32-bit words),
// and takes no word on the input side until it ends. Items are then handled one
// at a time. Allocate scans the store from word 0 at one word per cycle. Free,
// set and clear of a single bit turn the page index into a store word and bit
// offset by a reciprocal multiplication. Range actions walk every store word
// that they touch, and an index outside the managed pages or an empty range
// skips the walk. The bitmap store has one read and one write port, and the
// walk reads the next word while writing back the current one. The result
// word sits in an output register, so the next input word is taken while an
// earlier result still waits. Configuration writes are accepted at any time
// but belong in idle periods.
`timescale 1ns / 1ps

module page_bitmap_allocator
  import pba_pkg::*;
#(
  parameter int NUM_PAGES = DEF_NUM_PAGES,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // page_address, page_index, range_length, zero pad
  input  logic [ACTION_W-1:0]   s_tuser,   // action
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // alloc_address
  output logic [STATUS_W-1:0]   m_tuser,   // status
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  pba_cmd_t  cmd;
  pba_stat_t stat;

  assign s_tready = cmd.idle;

  pba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .stat     (stat),
    .cmd      (cmd)
  );

  pba_datapath #(
    .NUM_PAGES (NUM_PAGES),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tvalid  (s_tvalid),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Only a successful allocate carries a real address.
  a_fail_addr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_DONE) |-> (m_tdata == ADDR_NONE))
    else $error("failed result carries an address");

  a_no_input_in_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> !s_tready)
    else $error("input taken during clearing pass");

  // One item at a time: after an accept the input side closes.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item accepted while busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_DONE) || (m_tuser == ST_NO_FREE) ||
                 (m_tuser == ST_OUT_OF_RANGE))
    else $error("undefined status code");

endmodule

// ----- tb/tb.sv -----
// Testbench for the page bitmap allocator: directed and random actions checked against a bitmap model.
`timescale 1ns / 1ps

module tb;
  import pba_pkg::*;

  localparam int NUM_PAGES   = DEF_NUM_PAGES;
  localparam int HOLD_CYCLES = 300;
  localparam int END_PAUSE   = 200;
  localparam int PAD_W       = IN_DATA_W - ADDR_W - INDEX_W - LEN_W;

  // Action codes the block leaves unused; they must still produce a word.
  localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   alloc_address;
  } outcome_t;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic [ACTION_W-1:0]   s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]   m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Bitmap model and its copy of the configuration.
  bit                 page_used [NUM_PAGES];
  logic [SHIFT_W-1:0] model_shift = PAGE_SHIFT_RST;
  logic [PAGES_W-1:0] model_pages = PAGES_IN_USE_RST;
  outcome_t           awaited_outcomes[$];
  int                 granted_pages[$];

  int error_count   = 0;
  int send_idle_pct = 31;
  int recv_idle_pct = 51;
  bit hold_req      = 1'b0;

  page_bitmap_allocator u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #400_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int managed_limit();
    return (model_pages > NUM_PAGES) ? NUM_PAGES : int'(model_pages);
  endfunction

  function automatic void mark_pages(int first, int stop, bit used);
    for (int i = first; i < stop; i++) page_used[i] = used;
  endfunction

  // Applies one action to the bitmap model and returns the word it should produce.
  function automatic outcome_t predict_outcome(logic [ACTION_W-1:0] action,
                                               logic [ADDR_W-1:0] paddr,
                                               logic [INDEX_W-1:0] pidx,
                                               logic [LEN_W-1:0] plen);
    outcome_t    res;
    int          lim;
    int          stop;
    logic [63:0] wide;
    logic [31:0] idx;
    res.status        = ST_DONE;
    res.alloc_address = ADDR_NONE;
    lim = managed_limit();
    case (action)
      ACT_ALLOC: begin
        res.status = ST_NO_FREE;
        for (int i = 0; i < lim; i++) begin
          if (!page_used[i]) begin
            page_used[i] = 1'b1;
            wide = 64'(i) << model_shift;
            res.status        = ST_DONE;
            res.alloc_address = wide[31:0];
            granted_pages.push_back(i);
            break;
          end
        end
      end
      ACT_FREE: begin
        idx = paddr >> model_shift;
        if (idx >= 32'(lim)) res.status = ST_OUT_OF_RANGE;
        else page_used[idx] = 1'b0;
      end
      ACT_SET, ACT_CLR: begin
        if (int'(pidx) >= lim) res.status = ST_OUT_OF_RANGE;
        else page_used[pidx] = (action == ACT_SET);
      end
      ACT_SET_RANGE, ACT_CLR_RANGE: begin
        stop = int'(pidx) + int'(plen);
        if (int'(pidx) >= lim) res.status = ST_OUT_OF_RANGE;
        else mark_pages(int'(pidx), (stop > lim) ? lim : stop, action == ACT_SET_RANGE);
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Valid is left high after acceptance so back-to-back words need no second
  // assignment in the same step; drain_results lowers it.
  task automatic send_item(input logic [ACTION_W-1:0] action, input logic [ADDR_W-1:0] paddr,
                           input logic [INDEX_W-1:0] pidx, input logic [LEN_W-1:0] plen);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= action;
    s_tdata  <= {{PAD_W{1'b0}}, plen, pidx, paddr};
    do @(posedge clk); while (!s_tready);
    awaited_outcomes.push_back(predict_outcome(action, paddr, pidx, plen));
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (awaited_outcomes.size() != 0);
  endtask

  task automatic set_config(input logic [SHIFT_W-1:0] shift, input logic [PAGES_W-1:0] pages);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= REG_PAGE_SHIFT;
    cfg_data  <= CFG_DATA_W'(shift);
    do @(posedge clk); while (!cfg_ready);
    model_shift = shift;
    cfg_index <= REG_PAGES_IN_USE;
    cfg_data  <= CFG_DATA_W'(pages);
    do @(posedge clk); while (!cfg_ready);
    model_pages = pages;
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed traffic: frees usually return a page handed out earlier.
  task automatic send_random_item();
    int                  lim;
    int                  pick;
    int                  idx;
    int                  k;
    logic [ADDR_W-1:0]   paddr;
    logic [INDEX_W-1:0]  pidx;
    logic [LEN_W-1:0]    plen;
    logic [ACTION_W-1:0] action;
    lim   = managed_limit();
    paddr = $urandom();
    if ($urandom_range(99) < 80) begin
      idx = $urandom_range(0, lim + 7);
      if (idx >= NUM_PAGES) idx = NUM_PAGES - 1;
      pidx = INDEX_W'(idx);
    end else begin
      pidx = INDEX_W'($urandom());
    end
    pick = $urandom_range(99);
    if (pick < 85) plen = LEN_W'($urandom_range(0, 40));
    else if (pick < 95) plen = LEN_W'($urandom_range(0, 600));
    else if (pick < 98) plen = LEN_W'($urandom_range(0, NUM_PAGES));
    else plen = LEN_W'(NUM_PAGES);
    pick = $urandom_range(99);
    if (pick < 35) begin
      action = ACT_ALLOC;
    end else if (pick < 55) begin
      action = ACT_FREE;
      if (granted_pages.size() != 0 && $urandom_range(99) < 80) begin
        k   = $urandom_range(0, granted_pages.size() - 1);
        idx = granted_pages[k];
        granted_pages.delete(k);
        paddr = ADDR_W'(64'(idx) << model_shift) | (paddr & ((32'd1 << model_shift) - 32'd1));
      end
    end else if (pick < 65) begin
      action = ACT_SET;
    end else if (pick < 75) begin
      action = ACT_CLR;
    end else if (pick < 85) begin
      action = ACT_SET_RANGE;
    end else if (pick < 95) begin
      action = ACT_CLR_RANGE;
    end else begin
      action = $urandom_range(1) ? ACT_SPARE_A : ACT_SPARE_B;
    end
    send_item(action, paddr, pidx, plen);
  endtask

  task automatic test_basic_actions();
    send_item(ACT_ALLOC, '0, '0, '0);
    send_item(ACT_ALLOC, '0, '0, '0);
    send_item(ACT_ALLOC, '0, '0, '0);
    send_item(ACT_FREE, 32'h0000_1FFF, '0, '0);
    send_item(ACT_ALLOC, '0, '0, '0);
    send_item(ACT_SET, '0, 16'hFFFF, '0);
    send_item(ACT_CLR, '0, 16'hFFFF, '0);
    // Address far beyond the managed pages.
    send_item(ACT_FREE, 32'hFFFF_FFFF, '0, '0);
    send_item(ACT_SET_RANGE, '0, '0, '0);
    // Range running past the end is clipped; a second range fills the bitmap.
    send_item(ACT_SET_RANGE, '0, 16'd100, LEN_W'(NUM_PAGES));
    send_item(ACT_SET_RANGE, '0, '0, 17'd100);
    send_item(ACT_ALLOC, '0, '0, '0);
    send_item(ACT_CLR_RANGE, '0, '0, LEN_W'(NUM_PAGES));
    send_item(ACT_SPARE_A, 32'hFFFF_FFFF, 16'hFFFF, LEN_W'(NUM_PAGES));
    send_item(ACT_SPARE_B, '0, '0, '0);
  endtask

  // With a page shift of 20, the largest this bench uses, high page addresses wrap past 32 bits.
  task automatic test_address_wrap();
    set_config(5'd20, PAGES_W'(NUM_PAGES));
    send_item(ACT_SET_RANGE, '0, '0, 17'd4095);
    send_item(ACT_ALLOC, '0, '0, '0);
    send_item(ACT_ALLOC, '0, '0, '0);
    send_item(ACT_FREE, 32'hFFF0_0000, '0, '0);
    send_item(ACT_CLR_RANGE, '0, '0, LEN_W'(NUM_PAGES));
  endtask

  task automatic test_managed_limit();
    set_config(5'd1, '0);
    send_item(ACT_ALLOC, '0, '0, '0);
    send_item(ACT_SET, '0, '0, '0);
    send_item(ACT_CLR_RANGE, '0, '0, 17'd5);
    send_item(ACT_FREE, '0, '0, '0);
    set_config(5'd1, 17'd8);
    send_item(ACT_SET_RANGE, '0, '0, 17'd7);
    send_item(ACT_ALLOC, '0, '0, '0);
    send_item(ACT_ALLOC, '0, '0, '0);
    send_item(ACT_FREE, 32'd15, '0, '0);
    send_item(ACT_CLR_RANGE, '0, '0, 17'd8);
  endtask

  // The receiver stalls for a long stretch while words keep coming, so the
  // block backs up and holds off its input.
  task automatic test_output_hold();
    set_config(5'd12, 17'd512);
    send_idle_pct = 0;
    hold_req = 1'b1;
    for (int n = 0; n < 24; n++) send_random_item();
    drain_results();
  endtask

  task automatic test_random_phase(input int sender_idle, input int receiver_idle, input int count);
    send_idle_pct = sender_idle;
    recv_idle_pct = receiver_idle;
    for (int n = 0; n < count; n++) begin
      if (n % 150 == 0) begin
        set_config(SHIFT_W'($urandom_range(1, 20)),
                   ($urandom_range(5) == 0) ? PAGES_W'(NUM_PAGES)
                                           : PAGES_W'(8 * $urandom_range(1, 128)));
      end
      send_random_item();
    end
    drain_results();
  endtask

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_outcomes.size() == 0) begin
        $error("unexpected result word: status %0d, alloc_address %h", m_tuser, m_tdata);
        error_count++;
      end else begin
        want = awaited_outcomes.pop_front();
        if (m_tuser !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, m_tuser);
          error_count++;
        end
        if (m_tdata !== want.alloc_address) begin
          $error("alloc_address mismatch: expected %h, actual %h", want.alloc_address, m_tdata);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_basic_actions();
    test_address_wrap();
    test_managed_limit();
    test_random_phase(31, 51, 440);
    test_output_hold();
    test_random_phase(51, 31, 440);
    test_random_phase(0, 0, 440);
    drain_results();
    repeat (END_PAUSE) @(posedge clk);
    if (error_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
